[design/crr_pkg.sv]
// Shared types and constants for the control record receiver.
package crr_pkg;

    localparam int MAX_TERMS_DEFAULT = 4;
    localparam int TDATA_OUT_W       = 96;

    localparam logic [15:0] RATE_RESET   = 16'd100;
    localparam logic [7:0]  BYTE_MASK    = 8'hFF;

    localparam logic       KIND_WORD    = 1'b0;
    localparam logic       KIND_VERDICT = 1'b1;

    localparam logic [1:0] GROUP_D      = 2'd0;
    localparam logic [1:0] GROUP_INTEG  = 2'd3;

    localparam logic [1:0] VERDICT_OK       = 2'd0;
    localparam logic [1:0] VERDICT_CHECKSUM = 2'd1;
    localparam logic [1:0] VERDICT_COUNT    = 2'd2;

    typedef struct packed {
        logic        result_kind;
        logic [1:0]  word_group;
        logic [1:0]  word_index;
        logic [31:0] word_value;
        logic [1:0]  verdict;
        logic [7:0]  expected_checksum;
        logic [7:0]  control_mode_byte;
        logic [15:0] sample_rate;
        logic [7:0]  d_count;
        logic [7:0]  c_count;
        logic [7:0]  f_count;
    } result_t;

endpackage

[design/crr_parser.sv]
// Record parser: phase tracking, checksum fold, word assembly and result generation.
module crr_parser #(
    parameter int MAX_TERMS = crr_pkg::MAX_TERMS_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic [7:0]        data_byte,
    input  logic              first_byte,
    output logic              res_valid,
    output crr_pkg::result_t  res
);

    localparam int FW = $clog2(MAX_TERMS * 4 + 1);

    typedef enum logic [3:0] {
        PH_MODE  = 4'd0,
        PH_RATE  = 4'd1,
        PH_DCNT  = 4'd2,
        PH_DWORD = 4'd3,
        PH_CCNT  = 4'd4,
        PH_CWORD = 4'd5,
        PH_FCNT  = 4'd6,
        PH_FWORD = 4'd7,
        PH_INTEG = 4'd8,
        PH_CHECK = 4'd9,
        PH_IDLE  = 4'd10
    } phase_t;

    phase_t        phase_reg, phase_next, ph;
    logic [FW-1:0] fbc_reg, fbc_next, fbc_in, fbc_inc, idx_full;
    logic [7:0]    counts_reg [3];
    logic [7:0]    counts_next [3];
    logic [7:0]    sum_reg, sum_next, sum_in, sum_add, expect_sum;
    logic [8:0]    sum_wide;
    logic [31:0]   wa_reg, wa_next, wa_new, wa_base;
    logic [7:0]    mode_reg, mode_next;
    logic [15:0]   rate_reg, rate_next;
    logic [3:0]    ph_m2;
    logic [1:0]    grp, pos;
    logic [7:0]    cnt_g;
    logic          word_done, last_word;

    always_comb begin
        ph      = first_byte ? PH_MODE : phase_reg;
        fbc_in  = first_byte ? '0 : fbc_reg;
        sum_in  = first_byte ? 8'd0 : sum_reg;

        sum_wide = {1'b0, sum_in} + {1'b0, data_byte};
        sum_add  = sum_wide[8] ? (sum_wide[7:0] + 8'd1) : sum_wide[7:0];
        expect_sum = ~sum_in & crr_pkg::BYTE_MASK;

        ph_m2 = ph - 4'd2;
        grp   = ph_m2[2:1];
        case (grp)
            2'd0:    cnt_g = counts_reg[0];
            2'd1:    cnt_g = counts_reg[1];
            default: cnt_g = counts_reg[2];
        endcase

        pos     = fbc_in[1:0];
        wa_base = (pos == 2'd0) ? 32'd0 : wa_reg;
        case (pos)
            2'd0:    wa_new = wa_base | {24'd0, data_byte};
            2'd1:    wa_new = wa_base | {16'd0, data_byte, 8'd0};
            2'd2:    wa_new = wa_base | {8'd0, data_byte, 16'd0};
            default: wa_new = wa_base | {data_byte, 24'd0};
        endcase
        fbc_inc   = fbc_in + 1'b1;
        word_done = (fbc_inc[1:0] == 2'd0);
        idx_full  = (fbc_inc >> 2) - 1'b1;
        last_word = (10'(fbc_inc) >= {cnt_g, 2'b00});

        phase_next  = ph;
        fbc_next    = fbc_in;
        sum_next    = sum_in;
        wa_next     = wa_reg;
        mode_next   = mode_reg;
        rate_next   = rate_reg;
        counts_next = counts_reg;

        res_valid             = 1'b0;
        res                   = '0;
        res.result_kind       = crr_pkg::KIND_WORD;

        unique case (ph)
            PH_MODE: begin
                sum_next   = sum_add;
                mode_next  = data_byte;
                phase_next = PH_RATE;
                fbc_next   = '0;
            end
            PH_RATE: begin
                sum_next = sum_add;
                if (fbc_in == '0) begin
                    rate_next = {rate_reg[15:8], data_byte};
                    fbc_next  = FW'(1);
                end else begin
                    rate_next   = {data_byte, rate_reg[7:0]};
                    counts_next = '{8'd0, 8'd0, 8'd0};
                    phase_next  = PH_DCNT;
                    fbc_next    = '0;
                end
            end
            PH_DCNT, PH_CCNT, PH_FCNT: begin
                sum_next         = sum_add;
                counts_next[grp] = data_byte;
                fbc_next         = '0;
                if (data_byte > 8'(MAX_TERMS)) begin
                    phase_next    = PH_IDLE;
                    res_valid     = 1'b1;
                    res.result_kind = crr_pkg::KIND_VERDICT;
                    res.verdict   = crr_pkg::VERDICT_COUNT;
                end else if (data_byte != 8'd0) begin
                    phase_next = phase_t'(ph + 4'd1);
                end else begin
                    phase_next = phase_t'(ph + 4'd2);
                end
            end
            PH_DWORD, PH_CWORD, PH_FWORD: begin
                sum_next = sum_add;
                wa_next  = wa_new;
                fbc_next = fbc_inc;
                if (word_done) begin
                    res_valid      = 1'b1;
                    res.word_group = grp;
                    res.word_index = idx_full[1:0];
                    res.word_value = wa_new;
                    if (last_word) begin
                        phase_next = phase_t'(ph + 4'd1);
                        fbc_next   = '0;
                    end
                end
            end
            PH_INTEG: begin
                sum_next = sum_add;
                wa_next  = wa_new;
                fbc_next = fbc_inc;
                if (word_done) begin
                    res_valid      = 1'b1;
                    res.word_group = crr_pkg::GROUP_INTEG;
                    res.word_value = wa_new;
                    phase_next     = PH_CHECK;
                    fbc_next       = '0;
                end
            end
            PH_CHECK: begin
                phase_next            = PH_IDLE;
                res_valid             = 1'b1;
                res.result_kind       = crr_pkg::KIND_VERDICT;
                res.expected_checksum = expect_sum;
                res.verdict = (data_byte == expect_sum) ? crr_pkg::VERDICT_OK
                                                        : crr_pkg::VERDICT_CHECKSUM;
            end
            default: begin
            end
        endcase

        res.control_mode_byte = mode_next;
        res.sample_rate       = rate_next;
        res.d_count           = counts_next[0];
        res.c_count           = counts_next[1];
        res.f_count           = counts_next[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_MODE;
            fbc_reg    <= '0;
            sum_reg    <= 8'd0;
            wa_reg     <= 32'd0;
            mode_reg   <= 8'd0;
            rate_reg   <= crr_pkg::RATE_RESET;
            counts_reg <= '{8'd0, 8'd0, 8'd0};
        end else if (accept) begin
            phase_reg  <= phase_next;
            fbc_reg    <= fbc_next;
            sum_reg    <= sum_next;
            wa_reg     <= wa_next;
            mode_reg   <= mode_next;
            rate_reg   <= rate_next;
            counts_reg <= counts_next;
        end
    end

`ifndef SYNTHESIS
    a_verdict_idles: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && res_valid && res.result_kind == crr_pkg::KIND_VERDICT)
        |=> phase_reg == PH_IDLE)
        else $error("parser not idle after verdict");

    a_counts_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !first_byte && phase_reg == PH_RATE && fbc_reg != '0)
        |=> (counts_reg[0] == 8'd0 && counts_reg[1] == 8'd0
             && counts_reg[2] == 8'd0 && phase_reg == PH_DCNT))
        else $error("counts not cleared after rate");

    a_fbc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (!first_byte && (phase_reg == PH_DWORD || phase_reg == PH_CWORD
                         || phase_reg == PH_FWORD))
        |-> (10'(fbc_reg) < {cnt_g, 2'b00}))
        else $error("byte count past group end");
`endif

endmodule

[design/crr_out_reg.sv]
// Result register with stream handshake and word packing.
module crr_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             res_valid,
    input  crr_pkg::result_t res,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             accept,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [crr_pkg::TDATA_OUT_W-1:0] m_tdata,
    output logic             m_tuser
);

    logic             valid_reg, valid_next;
    crr_pkg::result_t res_reg;

    assign s_tready = !valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg && !m_tready;
        if (accept && res_valid) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && res_valid) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.result_kind;
    assign m_tdata  = {2'b00,
                       res_reg.f_count,
                       res_reg.c_count,
                       res_reg.d_count,
                       res_reg.sample_rate,
                       res_reg.control_mode_byte,
                       res_reg.expected_checksum,
                       res_reg.verdict,
                       res_reg.word_value,
                       res_reg.word_index,
                       res_reg.word_group};

endmodule

[design/control_record_receiver.sv]
// Top level of the control record receiver.
// Usage:
//   Input stream: one record byte per word on s_tdata; s_tuser set marks the
//   first byte of a record and restarts the parser. A word is taken when
//   s_tvalid and s_tready are both high.
//   Result stream: m_tuser is 0 for a completed coefficient or integral word,
//   1 for the record verdict (0 ok, 1 checksum mismatch, 2 count over limit).
//   m_tdata carries the word fields and the current mode, rate and counts.
//   Bytes that complete nothing give no result.
// Timing:
//   One byte per cycle sustained while m_tready is high. A result appears on
//   m_tvalid in the cycle after the byte that causes it is taken; the parse step
//   sits between the input handshake and a single result register.
//   While a result waits, a new byte is still taken if m_tready is high in the
//   same cycle; with m_tready low and a result held, s_tready drops.
// Reset:
//   aresetn low clears the parser to expect a mode byte, the rate to 100,
//   the counts, mode and checksum sum to zero, and empties the result register.
module control_record_receiver #(
    parameter int MAX_TERMS = crr_pkg::MAX_TERMS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // data_byte
    input  logic        s_tuser,  // first_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // word_group, word_index, word_value, verdict, expected_checksum,
    // control_mode_byte, sample_rate, d_count, c_count, f_count, zero pad
    output logic [crr_pkg::TDATA_OUT_W-1:0] m_tdata,
    output logic        m_tuser   // result_kind
);

    logic             accept;
    logic             res_valid;
    crr_pkg::result_t res;

    crr_parser #(
        .MAX_TERMS (MAX_TERMS)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .data_byte  (s_tdata),
        .first_byte (s_tuser),
        .res_valid  (res_valid),
        .res        (res)
    );

    crr_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .accept    (accept),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

[tb/sv/tb_top.sv]
// Self-checking stream testbench for the control record receiver: predicts every result word.
`timescale 1ns / 100ps

module tb_top;

    localparam int TERMS          = crr_pkg::MAX_TERMS_DEFAULT;
    localparam int RANDOM_BYTES   = 550;
    localparam int QUIET_TAIL     = 100;
    localparam int WATCHDOG_LIMIT = 500;

    typedef enum logic [3:0] {
        PH_MODE, PH_RATE, PH_D_CNT, PH_D_WORDS, PH_C_CNT, PH_C_WORDS,
        PH_F_CNT, PH_F_WORDS, PH_INTEG, PH_CHECK, PH_IDLE
    } phase_e;

    logic aclk     = 1'b0;
    logic aresetn  = 1'b0;
    logic s_tvalid = 1'b0;
    logic [7:0] s_tdata = 8'h00;
    logic s_tuser  = 1'b0;
    logic m_tready = 1'b0;
    wire  s_tready;
    wire  m_tvalid;
    wire  [crr_pkg::TDATA_OUT_W-1:0] m_tdata;
    wire  m_tuser;

    // record parser state
    phase_e      phase      = PH_MODE;
    logic [4:0]  field_bytes = 5'd0;
    logic [7:0]  term_count [3] = '{8'd0, 8'd0, 8'd0};
    logic [7:0]  byte_sum   = 8'd0;
    logic [31:0] word_buf   = 32'd0;
    logic [7:0]  mode_reg   = 8'd0;
    logic [15:0] rate_reg   = crr_pkg::RATE_RESET;

    crr_pkg::result_t pending_results [$];
    int      mismatches  = 0;
    int      busy_bytes  = 0;
    int      stall_left  = 0;
    int      idle_cycles = 0;
    bit      quiet       = 1'b0;
    bit      running     = 1'b0;

    always #5 aclk = ~aclk;

    control_record_receiver uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    function automatic logic [7:0] fold_sum(input logic [7:0] acc, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, acc} + {1'b0, b};
        return s[8] ? s[7:0] + 8'd1 : s[7:0];
    endfunction

    function automatic crr_pkg::result_t common_fields(input logic kind);
        crr_pkg::result_t r;
        r = '0;
        r.result_kind       = kind;
        r.control_mode_byte = mode_reg;
        r.sample_rate       = rate_reg;
        r.d_count           = term_count[0];
        r.c_count           = term_count[1];
        r.f_count           = term_count[2];
        return r;
    endfunction

    function automatic bit take_word_byte(input logic [7:0] b);
        if (field_bytes[1:0] == 2'd0)
            word_buf = 32'd0;
        word_buf = word_buf | (32'(b) << (8 * field_bytes[1:0]));
        field_bytes = field_bytes + 5'd1;
        return field_bytes[1:0] == 2'd0;
    endfunction

    // Advance the parser by one byte; return 0 when the byte is ignored.
    function automatic bit parse_record_byte(input logic [7:0] b, input logic first);
        crr_pkg::result_t r;
        int g;
        int idx;
        if (first) begin
            phase       = PH_MODE;
            field_bytes = 5'd0;
            byte_sum    = 8'd0;
        end
        if (phase == PH_IDLE)
            return 1'b0;
        g = (int'(phase) - int'(PH_D_CNT)) >> 1;
        case (phase)
            PH_MODE: begin
                byte_sum    = fold_sum(byte_sum, b);
                mode_reg    = b;
                phase       = PH_RATE;
                field_bytes = 5'd0;
            end
            PH_RATE: begin
                byte_sum = fold_sum(byte_sum, b);
                if (field_bytes == 5'd0) begin
                    rate_reg[7:0] = b;
                    field_bytes   = 5'd1;
                end else begin
                    rate_reg[15:8] = b;
                    term_count     = '{8'd0, 8'd0, 8'd0};
                    phase          = PH_D_CNT;
                    field_bytes    = 5'd0;
                end
            end
            PH_D_CNT, PH_C_CNT, PH_F_CNT: begin
                byte_sum      = fold_sum(byte_sum, b);
                term_count[g] = b;
                field_bytes   = 5'd0;
                if (int'(b) > TERMS) begin
                    phase     = PH_IDLE;
                    r         = common_fields(crr_pkg::KIND_VERDICT);
                    r.verdict = crr_pkg::VERDICT_COUNT;
                    pending_results.push_back(r);
                end else begin
                    phase = phase_e'((b != 8'd0) ? int'(phase) + 1 : int'(phase) + 2);
                end
            end
            PH_D_WORDS, PH_C_WORDS, PH_F_WORDS: begin
                byte_sum = fold_sum(byte_sum, b);
                if (take_word_byte(b)) begin
                    idx          = int'(field_bytes >> 2) - 1;
                    r            = common_fields(crr_pkg::KIND_WORD);
                    r.word_group = 2'(g);
                    r.word_index = 2'(idx);
                    r.word_value = word_buf;
                    pending_results.push_back(r);
                    if (int'(field_bytes) >= int'(term_count[g]) * 4) begin
                        phase       = phase_e'(int'(phase) + 1);
                        field_bytes = 5'd0;
                    end
                end
            end
            PH_INTEG: begin
                byte_sum = fold_sum(byte_sum, b);
                if (take_word_byte(b)) begin
                    r            = common_fields(crr_pkg::KIND_WORD);
                    r.word_group = crr_pkg::GROUP_INTEG;
                    r.word_value = word_buf;
                    pending_results.push_back(r);
                    phase       = PH_CHECK;
                    field_bytes = 5'd0;
                end
            end
            PH_CHECK: begin
                phase               = PH_IDLE;
                r                   = common_fields(crr_pkg::KIND_VERDICT);
                r.expected_checksum = ~byte_sum;
                r.verdict           = (b == ~byte_sum) ? crr_pkg::VERDICT_OK
                                                       : crr_pkg::VERDICT_CHECKSUM;
                pending_results.push_back(r);
            end
            default: ;
        endcase
        return 1'b1;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic first);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 9);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= first;
        do @(posedge aclk); while (!s_tready);
        if (parse_record_byte(b, first))
            busy_bytes++;
    endtask

    // Build one record; cut >= 0 drops the record from that byte on.
    task automatic send_record(input bit flag, input logic [7:0] mode, input logic [15:0] rate,
                               input int dc, input int cc, input int fc,
                               input bit bad_sum, input int cut);
        logic [7:0] body [$];
        logic [7:0] acc;
        int counts [3];
        bit over;
        counts = '{dc, cc, fc};
        over   = 1'b0;
        body.push_back(mode);
        body.push_back(rate[7:0]);
        body.push_back(rate[15:8]);
        for (int g = 0; g < 3 && !over; g++) begin
            body.push_back(8'(counts[g]));
            if (counts[g] > TERMS)
                over = 1'b1;
            else
                for (int i = 0; i < 4 * counts[g]; i++)
                    body.push_back(8'($urandom_range(0, 255)));
        end
        if (!over) begin
            for (int i = 0; i < 4; i++)
                body.push_back(8'($urandom_range(0, 255)));
            acc = 8'd0;
            foreach (body[i])
                acc = fold_sum(acc, body[i]);
            acc = ~acc;
            if (bad_sum)
                acc = acc ^ 8'($urandom_range(1, 255));
            body.push_back(acc);
        end
        foreach (body[i]) begin
            if (cut >= 0 && i == cut)
                break;
            send_byte(body[i], (i == 0) ? flag : 1'b0);
        end
    endtask

    task automatic test_start_without_flag;
        send_record(1'b0, 8'hFF, 16'hFFFF, 0, 0, 0, 1'b0, -1);
    endtask

    task automatic test_idle_bytes;
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
    endtask

    task automatic test_count_over_limit;
        send_record(1'b1, 8'h00, 16'h0000, 0, 0, TERMS + 1, 1'b0, -1);
        send_record(1'b1, 8'h5A, 16'h0001, 255, 0, 0, 1'b0, -1);
    endtask

    task automatic test_random_records;
        int stop_at;
        int counts [3];
        int cut;
        stop_at = busy_bytes + RANDOM_BYTES;
        while (busy_bytes < stop_at) begin
            quiet = (busy_bytes >= stop_at - QUIET_TAIL);
            for (int g = 0; g < 3; g++)
                counts[g] = ($urandom_range(0, 19) == 0) ? $urandom_range(TERMS + 1, 255)
                                                         : $urandom_range(0, TERMS);
            cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20) : -1;
            send_record($urandom_range(0, 19) != 0, 8'($urandom_range(0, 255)),
                        16'($urandom_range(0, 65535)), counts[0], counts[1], counts[2],
                        $urandom_range(0, 7) == 0, cut);
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : collect_results
        crr_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result word with none expected: kind %0d data 0x%0h", m_tuser, m_tdata);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("result_kind", want.result_kind, m_tuser);
                check_field("word_group", want.word_group, m_tdata[1:0]);
                check_field("word_index", want.word_index, m_tdata[3:2]);
                check_field("word_value", want.word_value, m_tdata[35:4]);
                check_field("verdict", want.verdict, m_tdata[37:36]);
                check_field("expected_checksum", want.expected_checksum, m_tdata[45:38]);
                check_field("control_mode_byte", want.control_mode_byte, m_tdata[53:46]);
                check_field("sample_rate", want.sample_rate, m_tdata[69:54]);
                check_field("d_count", want.d_count, m_tdata[77:70]);
                check_field("c_count", want.c_count, m_tdata[85:78]);
                check_field("f_count", want.f_count, m_tdata[93:86]);
            end
        end
    end

    // Hold m_tready low in random bursts.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 8);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!running || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        running = 1'b1;
        test_start_without_flag();
        test_idle_bytes();
        test_count_over_limit();
        test_random_records();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
